// ===== rtl/core/lxr_pkg.sv =====
// Package for the lagged XOR random table seeder.
// Holds the sizes, generator constants, datapath command word and controller states.
// No dependencies.
`default_nettype none
package lxr_pkg;

   localparam int TABLE_SIZE = 521;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int WORDS      = 17;
   localparam int WIN_W      = $clog2(WORDS);
   localparam int LAG        = 32;
   localparam int PASSES     = 3;
   localparam int SHL        = 23;
   localparam int SHR        = 9;
   localparam int TICK_DIV   = 60;
   localparam int DIV_SHIFT  = 37;
   localparam int LCG_STEPS  = WORDS * 32;

   localparam logic [31:0]      LCG_MULT     = 32'h5D58_8B65;
   localparam logic [31:0]      DIV_MULT     = 32'h8888_8889;
   localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(TABLE_SIZE - 1);
   localparam logic [IDX_W-1:0] LAST_WORD    = IDX_W'(WORDS - 1);
   localparam logic [IDX_W-1:0] FIRST_GEN    = IDX_W'(WORDS);
   localparam logic [IDX_W-1:0] LAST_LCG     = IDX_W'(LCG_STEPS - 1);
   localparam logic [IDX_W-1:0] LAG_IDX      = IDX_W'(LAG);
   localparam logic [IDX_W-1:0] WRAP_OFS     = IDX_W'(TABLE_SIZE - LAG);
   localparam logic [1:0]       LAST_PASS    = 2'(PASSES - 1);

   localparam logic CMD_SEED = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_DIV,
      OP_LCG_LOAD,
      OP_LCG,
      OP_FIX,
      OP_INIT_WR,
      OP_GEN,
      OP_WARM,
      OP_FINISH,
      OP_READ,
      OP_RSP
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      logic             flag;
      logic [IDX_W-1:0] idx;
   } dp_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_LOAD,
      ST_LCG,
      ST_FIX,
      ST_INIT,
      ST_GEN,
      ST_WARM,
      ST_DRAIN,
      ST_READ,
      ST_RESP
   } ctrl_state_type;

endpackage
`default_nettype wire

// ===== rtl/core/lxr_dp.sv =====
// Datapath of the lagged XOR random table seeder: tick divider, generator,
// word window, byte table memory and result registers. Uses lxr_pkg.
`default_nettype none
module lxr_dp
   import lxr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dp_cmd_type       cmd,
   input  wire logic [31:0]      req_tick_count,
   input  wire logic [IDX_W-1:0] req_read_index,
   output logic [7:0]            rsp_byte_value,
   output logic [IDX_W-1:0]      rsp_read_pointer
);

   logic [31:0]      div_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [31:0]      x_ff;
   logic [31:0]      bits_ff;
   logic [31:0]      win_ff [WORDS];
   logic [7:0]       byte_mem [TABLE_SIZE];
   logic [7:0]       qa_ff;
   logic [7:0]       qb_ff;
   logic             warm_pend_ff;
   logic [IDX_W-1:0] warm_addr_ff;
   logic             seeded_ff;
   logic [IDX_W-1:0] ptr_ff;
   logic [7:0]       rsp_byte_ff;
   logic [IDX_W-1:0] rsp_ptr_ff;

   logic [63:0]      div_prod;
   logic [31:0]      x_in;
   logic [31:0]      bits_in;
   logic [31:0]      fix_word;
   logic [31:0]      gen_word;
   logic             rd_ok;
   logic             we;
   logic [IDX_W-1:0] wa;
   logic [7:0]       wd;
   logic             re;
   logic [IDX_W-1:0] ra;
   logic [IDX_W-1:0] rb;

   assign div_prod  = 64'(div_ff) * 64'(DIV_MULT);
   assign x_in      = x_ff * LCG_MULT + 32'd1;
   assign bits_in   = {x_in[31], bits_ff[31:1]};
   assign fix_word  = (win_ff[WORDS-1] << SHL) ^ (win_ff[0] >> SHR) ^ win_ff[WORDS-2];
   assign gen_word  = (win_ff[0] << SHL) ^ (win_ff[1] >> SHR) ^ win_ff[WORDS-1];
   assign rd_ok     = rd_idx_ff < IDX_W'(TABLE_SIZE);

   always_comb begin
      we = 1'b0;
      wa = cmd.idx;
      wd = 8'd0;
      re = 1'b0;
      ra = cmd.idx;
      rb = (cmd.idx < LAG_IDX) ? cmd.idx + WRAP_OFS : cmd.idx - LAG_IDX;
      case (cmd.op)
         OP_INIT_WR: begin
            we = 1'b1;
            wd = win_ff[cmd.idx[WIN_W-1:0]][7:0];
         end
         OP_GEN: begin
            we = 1'b1;
            wd = gen_word[7:0];
         end
         OP_WARM: re = 1'b1;
         OP_READ: begin
            re = 1'b1;
            ra = rd_ok ? rd_idx_ff : '0;
            rb = '0;
         end
         default: ;
      endcase
      if (warm_pend_ff) begin
         we = 1'b1;
         wa = warm_addr_ff;
         wd = qa_ff ^ qb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         byte_mem[wa] <= wd;
      end
      if (re) begin
         qa_ff <= byte_mem[ra];
         qb_ff <= byte_mem[rb];
      end
   end

   always_ff @(posedge clock) begin
      warm_addr_ff <= cmd.idx;
      case (cmd.op)
         OP_LATCH: begin
            div_ff    <= req_tick_count;
            rd_idx_ff <= req_read_index;
         end
         OP_DIV: div_ff <= 32'(div_prod >> DIV_SHIFT);
         OP_LCG_LOAD: begin
            x_ff    <= div_ff;
            bits_ff <= 32'd0;
         end
         OP_LCG: begin
            x_ff    <= x_in;
            bits_ff <= bits_in;
            if (cmd.flag) begin
               for (int i = 0; i < WORDS - 1; i++) begin
                  win_ff[i] <= win_ff[i+1];
               end
               win_ff[WORDS-1] <= bits_in;
            end
         end
         OP_FIX: win_ff[WORDS-1] <= fix_word;
         OP_GEN: begin
            for (int i = 0; i < WORDS - 1; i++) begin
               win_ff[i] <= win_ff[i+1];
            end
            win_ff[WORDS-1] <= gen_word;
         end
         OP_RSP: begin
            rsp_byte_ff <= (cmd.flag && seeded_ff && rd_ok) ? qa_ff : 8'd0;
            rsp_ptr_ff  <= ptr_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_pend_ff <= 1'b0;
         seeded_ff    <= 1'b0;
         ptr_ff       <= '0;
      end else begin
         warm_pend_ff <= (cmd.op == OP_WARM);
         if (cmd.op == OP_FINISH) begin
            seeded_ff <= 1'b1;
            ptr_ff    <= LAST_IDX;
         end
      end
   end

   assign rsp_byte_value   = rsp_byte_ff;
   assign rsp_read_pointer = rsp_ptr_ff;

endmodule
`default_nettype wire

// ===== rtl/core/lxr_ctrl.sv =====
// Controller of the lagged XOR random table seeder: sequences divide, generator,
// table build, warm-up passes and the result handshake. Uses lxr_pkg.
`default_nettype none
module lxr_ctrl
   import lxr_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_stall,
   input  wire logic   req_command,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   output dp_cmd_type  cmd
);

   ctrl_state_type   state_ff, state_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [1:0]       pass_ff, pass_in;
   logic             is_read_ff, is_read_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         pass_ff      <= '0;
         is_read_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pass_ff      <= pass_in;
         is_read_ff   <= is_read_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      pass_in      = pass_ff;
      is_read_in   = is_read_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      cmd.op       = OP_NONE;
      cmd.flag     = 1'b0;
      cmd.idx      = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op     = OP_LATCH;
               is_read_in = (req_command == CMD_READ);
               step_in    = '0;
               state_in   = (req_command == CMD_READ) ? ST_READ : ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.op   = OP_DIV;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.op   = OP_LCG_LOAD;
            step_in  = '0;
            state_in = ST_LCG;
         end
         ST_LCG: begin
            cmd.op   = OP_LCG;
            cmd.flag = (step_ff[4:0] == 5'd31);
            step_in  = step_ff + 1'b1;
            if (step_ff == LAST_LCG) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.op   = OP_FIX;
            step_in  = '0;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.op  = OP_INIT_WR;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_WORD) begin
               step_in  = FIRST_GEN;
               state_in = ST_GEN;
            end
         end
         ST_GEN: begin
            cmd.op  = OP_GEN;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_IDX) begin
               step_in  = '0;
               pass_in  = '0;
               state_in = ST_WARM;
            end
         end
         ST_WARM: begin
            cmd.op  = OP_WARM;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_IDX) begin
               step_in = '0;
               pass_in = pass_ff + 1'b1;
               if (pass_ff == LAST_PASS) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            cmd.op   = OP_FINISH;
            state_in = ST_RESP;
         end
         ST_READ: begin
            cmd.op   = OP_READ;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = OP_RSP;
               cmd.flag     = is_read_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/core/lagged_xor_rng_seeder_top.sv =====
// Top level of the lagged XOR random table seeder.
// Instantiates lxr_ctrl and lxr_dp; uses lxr_pkg.
//
// A seed word divides the tick count by 60, runs the 544-step generator,
// builds the 521-byte table and applies three warm-up passes, in the steps
// divide by reciprocal multiplication, generator load, one generator step
// per cycle through the generator's 32x32 multiplier, word-16 fix, one table
// byte per cycle through the table memory's single write port, the warm-up
// passes, final write and result load. Once a result loads, the block
// returns to idle and takes the next word. Before the first seed the table
// reads as zeros. The block takes a new word while a finished result still
// waits in the output register, and works on one word at a time.
`default_nettype none
module lagged_xor_rng_seeder_top
   import lxr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_command,
   input  wire logic [31:0]      req_tick_count,
   input  wire logic [IDX_W-1:0] req_read_index,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [7:0]            rsp_byte_value,
   output logic [IDX_W-1:0]      rsp_read_pointer
);

   dp_cmd_type cmd;

   lxr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd)
   );

   lxr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_tick_count   (req_tick_count),
      .req_read_index   (req_read_index),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_read_pointer (rsp_read_pointer)
   );

endmodule
`default_nettype wire
